### design/tms_pkg.sv
// Package: command codes, status codes and shared types of the matrix stack.
package tms_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_IDENTITY  = 3'd2,
    CMD_TRANSLATE = 3'd3,
    CMD_SCALE     = 3'd4,
    CMD_LOAD_ROW  = 3'd5,
    CMD_MULTIPLY  = 3'd6,
    CMD_READ_ROW  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POP_LAST  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COPY,
    BK_IDENT,
    BK_MUL,
    BK_READ,
    BK_DONE
  } bk_state_t;

  // Request as it travels from front to back.
  typedef struct packed {
    cmd_t        command;
    logic [1:0]  row;
    logic [31:0] val0;
    logic [31:0] val1;
    logic [31:0] val2;
    logic [31:0] val3;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out0;
    logic [31:0] out1;
    logic [31:0] out2;
    logic [31:0] out3;
    logic [5:0]  level;
  } rsp_t;

endpackage

### design/tms_if.sv
// Interfaces: request and response channels of the matrix stack.
interface tms_req_if;
  import tms_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [1:0]  row;
  logic [31:0] val0;
  logic [31:0] val1;
  logic [31:0] val2;
  logic [31:0] val3;
  modport source (output valid, command, row, val0, val1, val2, val3, input ready);
  modport sink (input valid, command, row, val0, val1, val2, val3, output ready);
endinterface

interface tms_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out0;
  logic [31:0] out1;
  logic [31:0] out2;
  logic [31:0] out3;
  logic [5:0]  level;
  modport source (output valid, status, out0, out1, out2, out3, level, input ready);
  modport sink (input valid, status, out0, out1, out2, out3, level, output ready);
endinterface

### design/tms_front.sv
// Front end: takes requests and queues them for the back end.
module tms_front
  import tms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  tms_req_if.sink      req,
  output logic         q_valid,
  input  logic         q_pop,
  output req_t         q_head
);

  localparam int QD = 2;

  req_t       fifo [QD];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] count;
  logic       push;

  assign req.ready = (count != 2'(QD));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_head    = fifo[rd_ptr];

  // Store incoming requests.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{command: cmd_t'(req.command), row: req.row, val0: req.val0,
                        val1: req.val1, val2: req.val2, val3: req.val3};
    end
  end

  // Advance the pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'(QD))
    else $error("queue overfilled");
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> count != 2'(QD))
    else $error("push into full queue");

endmodule

### design/tms_back.sv
// Back end: stack memory, operand matrix and the shared multiply datapath.
module tms_back
  import tms_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_pop,
  input  req_t  q_head,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output rsp_t  rsp
);

  localparam int AW = $clog2(DEPTH) + 4;
  localparam int TW = $clog2(DEPTH);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] mem [DEPTH*16];
  logic signed [31:0] opm [16];
  logic [TW-1:0]      top;
  logic               top0_written;   // entry zero holds its reset identity until written

  bk_state_t state, state_next;
  req_t      cur;
  logic [3:0] idx;         // element counter
  logic [3:0] widx;        // write index (registered copy of idx in copy and read; own counter in multiply writeback)
  logic [4:0] wcnt;
  logic       mul_wb;
  logic       mul_issue;
  logic       rd_vld;
  logic signed [31:0] rd_data;
  logic signed [63:0] prod;
  logic signed [63:0] prod_tr;
  logic signed [49:0] acc;
  logic signed [31:0] res [16];
  logic signed [31:0] rowbuf [4];
  rsp_t out_reg;
  logic out_vld;

  // Operand element E[k][c]
  function automatic logic signed [31:0] e_elem(input req_t r, input logic [1:0] k,
                                                input logic [1:0] c,
                                                input logic signed [31:0] opv);
    logic signed [31:0] v;
    v = (k == c) ? ONE : 32'sd0;
    case (r.command)
      CMD_TRANSLATE: begin
        if (c == 2'd3 && k != 2'd3)
          v = (k == 2'd0) ? r.val0 : (k == 2'd1) ? r.val1 : r.val2;
      end
      CMD_SCALE: begin
        if (c == k && k != 2'd3)
          v = (k == 2'd0) ? r.val0 : (k == 2'd1) ? r.val1 : r.val2;
      end
      CMD_MULTIPLY: v = opv;
      default: v = v;
    endcase
    return v;
  endfunction

  // Element of top at (r,k); the multiply step counter gives r,c,k.
  logic [5:0] mstep;       // r(2) c(2) k(2)
  logic [1:0] m_r, m_c, m_k;
  assign m_r = mstep[5:4];
  assign m_c = mstep[3:2];
  assign m_k = mstep[1:0];

  // Issue each of the sixty-four products exactly once.
  assign mul_issue = (state == BK_MUL) && !mul_wb && (wcnt == 5'd0);

  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic signed [31:0] e_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {top, 4'd0};
    case (state)
      BK_COPY:  begin rd_en = 1'b1; rd_addr = {top, idx}; end
      BK_MUL:   begin rd_en = 1'b1; rd_addr = {top, m_r, m_k}; end
      BK_READ:  begin rd_en = 1'b1; rd_addr = {top, cur.row, idx[1:0]}; end
      default:  ;
    endcase
  end

  // Registered memory read; entry zero reads identity until first written.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_addr[AW-1:4] == '0 && !top0_written)
        rd_data <= (rd_addr[3:2] == rd_addr[1:0]) ? ONE : 32'sd0;
      else
        rd_data <= mem[rd_addr];
    end
    e_q <= e_elem(cur, m_k, m_c, opm[{m_k, m_c}]);
  end

  // Multiply pipeline: read -> product -> accumulate.
  logic       p_vld;
  always_ff @(posedge clk) begin
    prod   <= rd_data * e_q;
    if (rst) begin
      rd_vld <= 1'b0; p_vld <= 1'b0;
    end else begin
      rd_vld <= mul_issue;
      p_vld  <= rd_vld;
    end
  end
  assign prod_tr = prod >>> FRAC_BITS;

  logic [5:0] s1, s2;
  always_ff @(posedge clk) begin
    s1 <= mstep;
    s2 <= s1;
  end

  logic signed [49:0] acc_next;
  assign acc_next = ((s2[1:0] == 2'd0) ? 50'sd0 : acc) + 50'(prod_tr);
  logic signed [31:0] sat_v;
  always_comb begin
    if (acc_next > 50'sd2147483647) sat_v = 32'sh7FFFFFFF;
    else if (acc_next < -50'sd2147483648) sat_v = 32'sh80000000;
    else sat_v = 32'(acc_next);
  end

  always_ff @(posedge clk) begin
    if (p_vld) begin
      acc <= acc_next;
      if (s2[1:0] == 2'd3) res[s2[5:2]] <= sat_v;
    end
  end

  // Next-state logic.
  logic       last_issue;
  assign last_issue = (mstep == 6'd63);
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && !out_vld) begin
          case (q_head.command)
            CMD_PUSH:      state_next = (32'(top) + 1 >= DEPTH) ? BK_DONE : BK_COPY;
            CMD_IDENTITY:  state_next = BK_IDENT;
            CMD_TRANSLATE, CMD_SCALE, CMD_MULTIPLY: state_next = BK_MUL;
            CMD_READ_ROW:  state_next = BK_READ;
            default:       state_next = BK_DONE;
          endcase
        end
      end
      BK_COPY:  if (wcnt == 5'd16) state_next = BK_DONE;
      BK_IDENT: if (idx == 4'd15) state_next = BK_DONE;
      BK_MUL:   if (wcnt == 5'd16) state_next = BK_DONE;
      BK_READ:  if (wcnt == 5'd4) state_next = BK_DONE;
      BK_DONE:  state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  assign q_pop = (state == BK_IDLE) && q_valid && !out_vld;

  // Memory write port for copy and identity.
  logic       mem_we;
  logic [AW-1:0] mem_wa;
  logic signed [31:0] mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {top, idx};
    mem_wd = 32'sd0;
    case (state)
      BK_COPY: begin
        mem_we = (wcnt >= 5'd1) && (wcnt <= 5'd16);
        mem_wa = {top + TW'(1), widx};
        mem_wd = rd_data;
      end
      BK_IDENT: begin
        mem_we = 1'b1;
        mem_wa = {top, idx};
        mem_wd = (idx[3:2] == idx[1:0]) ? ONE : 32'sd0;
      end
      default: ;
    endcase
  end

  // Memory writes (copy, identity, multiply writeback of res) and row-read capture.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mul_wb) mem[{top, widx}] <= res[widx];
    if (state == BK_READ && wcnt >= 5'd1 && wcnt <= 5'd4) rowbuf[widx[1:0]] <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      top <= '0;
      top0_written <= 1'b0;
      idx <= '0; widx <= '0; wcnt <= '0; mstep <= '0; mul_wb <= 1'b0;
      out_vld <= 1'b0;
      for (int i = 0; i < 16; i++) opm[i] <= 32'sd0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready) out_vld <= 1'b0;
      case (state)
        BK_IDLE: begin
          idx <= '0; widx <= '0; wcnt <= '0; mstep <= '0; mul_wb <= 1'b0;
          if (q_pop) begin
            cur <= q_head;
            if (q_head.command == CMD_LOAD_ROW) begin
              opm[{q_head.row, 2'd0}] <= q_head.val0;
              opm[{q_head.row, 2'd1}] <= q_head.val1;
              opm[{q_head.row, 2'd2}] <= q_head.val2;
              opm[{q_head.row, 2'd3}] <= q_head.val3;
            end
          end
        end
        BK_COPY, BK_READ: begin
          idx  <= idx + 4'd1;
          widx <= idx;
          wcnt <= wcnt + 5'd1;
        end
        BK_IDENT: begin
          idx <= idx + 4'd1;
          if (top == '0) top0_written <= 1'b1;
        end
        BK_MUL: begin
          if (!last_issue && !mul_wb) mstep <= mstep + 6'd1;
          // pipeline drain: wait after the last issue until the last result has reached res
          if (last_issue && !mul_wb) begin
            if (wcnt == 5'd3) begin
              mul_wb <= 1'b1; wcnt <= '0; widx <= '0;
            end else begin
              wcnt <= wcnt + 5'd1;
            end
          end
          if (mul_wb) begin
            if (top == '0) top0_written <= 1'b1;
            if (widx == 4'd15) begin
              mul_wb <= 1'b0; wcnt <= 5'd16;
            end else begin
              widx <= widx + 4'd1;
              wcnt <= wcnt + 5'd1;
            end
          end
        end
        BK_DONE: begin
          out_vld <= 1'b1;
          out_reg.out0 <= (cur.command == CMD_READ_ROW) ? rowbuf[0] : 32'sd0;
          out_reg.out1 <= (cur.command == CMD_READ_ROW) ? rowbuf[1] : 32'sd0;
          out_reg.out2 <= (cur.command == CMD_READ_ROW) ? rowbuf[2] : 32'sd0;
          out_reg.out3 <= (cur.command == CMD_READ_ROW) ? rowbuf[3] : 32'sd0;
          case (cur.command)
            CMD_PUSH: begin
              if (32'(top) + 1 >= DEPTH) begin
                out_reg.status <= ST_PUSH_FULL;
                out_reg.level <= 6'(top);
              end else begin
                out_reg.status <= ST_DONE;
                top <= top + TW'(1);
                out_reg.level <= 6'(top + TW'(1));
              end
            end
            CMD_POP: begin
              if (top == '0) begin
                out_reg.status <= ST_POP_LAST;
                out_reg.level <= 6'(top);
              end else begin
                out_reg.status <= ST_DONE;
                top <= top - TW'(1);
                out_reg.level <= 6'(top - TW'(1));
              end
            end
            default: begin
              out_reg.status <= ST_DONE;
              out_reg.level <= 6'(top);
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign rsp_valid = out_vld;
  assign rsp = out_reg;

  a_take_when_free: assert property (@(posedge clk) disable iff (rst) q_pop |-> !out_vld)
    else $error("request taken while response pending");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
                                   (state == BK_DONE) |-> !out_vld)
    else $error("response overwritten");
  a_wb_in_mul: assert property (@(posedge clk) disable iff (rst)
                                mul_wb |-> (state == BK_MUL))
    else $error("writeback outside multiply");

endmodule

### design/transform_matrix_stack.sv
// Top level: 4x4 Q16.16 transform matrix stack with push, pop and post-multiply.
// Each request yields one response, and the back end takes the next request only
// once the previous response has been accepted. A push with room copies sixteen
// elements of the top matrix into the next entry, each read before it is written;
// identity writes sixteen elements; read row reads four; translate, scale and
// multiply send sixty-four products one per cycle through a single 32x32
// multiplier, let the pipeline drain, then write sixteen results back. A two-entry
// queue separates intake from execution and registers each request ahead of the
// back end.
module transform_matrix_stack
  import tms_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  tms_req_if.sink   req,
  tms_rsp_if.source rsp
);

  logic q_valid, q_pop;
  req_t q_head;
  rsp_t r;

  tms_front u_front (
    .clk(clk), .rst(rst), .req(req), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  tms_back #(.DEPTH(DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(r)
  );

  assign rsp.status = r.status;
  assign rsp.out0   = r.out0;
  assign rsp.out1   = r.out1;
  assign rsp.out2   = r.out2;
  assign rsp.out3   = r.out3;
  assign rsp.level  = r.level;

endmodule
